>>> rtl/present80_block_cipher_defines.svh
// ----------------------------------------------------------------------------
// PRESENT-80 assertion macros
// Shared concurrent assertion helpers for the cipher RTL.
// ----------------------------------------------------------------------------
`ifndef PRESENT80_BLOCK_CIPHER_DEFINES_SVH
`define PRESENT80_BLOCK_CIPHER_DEFINES_SVH

// Checked on every rising edge of i_clk, quiet while reset is asserted.
`define PRS80_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define PRS80_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/prs80_pkg.sv
// ----------------------------------------------------------------------------
// PRESENT-80 package
// Widths, codes, S-box tables and the round and key schedule functions.
// ----------------------------------------------------------------------------
`default_nettype none

package prs80_pkg;

    localparam int BLK_W          = 64;
    localparam int KEY_W          = 80;
    localparam int KEY_HI_W       = 16;
    localparam int RC_W           = 5;
    localparam int NUM_ROUNDS_DEF = 31;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    typedef struct packed {
        logic vld;
        logic op;
    } t_stage_ctl;

    function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            4'hF: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic logic [3:0] sbox_inv(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'h5;
            4'h1: y = 4'hE;
            4'h2: y = 4'hF;
            4'h3: y = 4'h8;
            4'h4: y = 4'hC;
            4'h5: y = 4'h1;
            4'h6: y = 4'h2;
            4'h7: y = 4'hD;
            4'h8: y = 4'hB;
            4'h9: y = 4'h4;
            4'hA: y = 4'h6;
            4'hB: y = 4'h3;
            4'hC: y = 4'h0;
            4'hD: y = 4'h7;
            4'hE: y = 4'h9;
            4'hF: y = 4'hA;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic logic [BLK_W-1:0] sub_fwd(input logic [BLK_W-1:0] x);
        logic [BLK_W-1:0] y;
        for (int n = 0; n < BLK_W / 4; n++) begin
            y[4*n +: 4] = sbox_fwd(x[4*n +: 4]);
        end
        return y;
    endfunction

    function automatic logic [BLK_W-1:0] sub_inv(input logic [BLK_W-1:0] x);
        logic [BLK_W-1:0] y;
        for (int n = 0; n < BLK_W / 4; n++) begin
            y[4*n +: 4] = sbox_inv(x[4*n +: 4]);
        end
        return y;
    endfunction

    // Bit b moves to bit 16*(b mod 4) + b/4.
    function automatic logic [BLK_W-1:0] perm_fwd(input logic [BLK_W-1:0] x);
        logic [BLK_W-1:0] y;
        for (int b = 0; b < BLK_W; b++) begin
            y[((b & 3) << 4) + (b >> 2)] = x[b];
        end
        return y;
    endfunction

    function automatic logic [BLK_W-1:0] perm_inv(input logic [BLK_W-1:0] x);
        logic [BLK_W-1:0] y;
        for (int b = 0; b < BLK_W; b++) begin
            y[b] = x[((b & 3) << 4) + (b >> 2)];
        end
        return y;
    endfunction

    // One key schedule step: rotate left by 61, S-box on the top nibble,
    // round counter into bits 19..15.
    function automatic logic [KEY_W-1:0] key_next(input logic [KEY_W-1:0] k,
                                                  input logic [RC_W-1:0]  rc);
        logic [KEY_W-1:0] y;
        y           = {k[18:0], k[KEY_W-1:19]};
        y[79:76]    = sbox_fwd(y[79:76]);
        y[19:15]    = y[19:15] ^ rc;
        return y;
    endfunction

endpackage

`default_nettype wire

>>> rtl/prs80_key_cell.sv
// ----------------------------------------------------------------------------
// PRESENT-80 key schedule cell
// Holds one key schedule state, derived each cycle from its left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module prs80_key_cell #(
    parameter int RC = 1
) (
    input  wire logic                       i_clk,
    input  wire logic [prs80_pkg::KEY_W-1:0] i_key,
    output logic      [prs80_pkg::KEY_W-1:0] o_key
);
    import prs80_pkg::*;

    localparam logic [RC_W-1:0] RC_BITS = RC_W'(RC);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;

    assign n_key = key_next(i_key, RC_BITS);

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

`default_nettype wire

>>> rtl/prs80_round_cell.sv
// ----------------------------------------------------------------------------
// PRESENT-80 round cell
// One registered cipher round, forward or inverse as the beat's opcode says.
// ----------------------------------------------------------------------------
`default_nettype none

module prs80_round_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire prs80_pkg::t_stage_ctl       i_ctl,
    input  wire logic [prs80_pkg::BLK_W-1:0] i_state,
    input  wire logic [prs80_pkg::BLK_W-1:0] i_rk_enc,
    input  wire logic [prs80_pkg::BLK_W-1:0] i_rk_dec,
    output prs80_pkg::t_stage_ctl            o_ctl,
    output logic      [prs80_pkg::BLK_W-1:0] o_state
);
    import prs80_pkg::*;

    t_stage_ctl       r_ctl;
    logic [BLK_W-1:0] r_state;
    logic [BLK_W-1:0] n_state;
    logic [BLK_W-1:0] w_mix;

    always_comb begin
        if (i_ctl.op == OP_DEC) begin
            w_mix   = i_state ^ i_rk_dec;
            n_state = sub_inv(perm_inv(w_mix));
        end else begin
            w_mix   = i_state ^ i_rk_enc;
            n_state = perm_fwd(sub_fwd(w_mix));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;

endmodule

`default_nettype wire

>>> rtl/present80_block_cipher.sv
// ----------------------------------------------------------------------------
// PRESENT-80 block cipher
// Fully unrolled round pipeline with a parallel key schedule chain.
// ----------------------------------------------------------------------------
// Blocks enter on the s_axis channel (tdata = block, tuser = opcode, 0 for
// encrypt and 1 for decrypt) and leave on the m_axis channel. The key is
// written through the cfg channel: index 0 holds key bits 79..64 in the low
// 16 data bits, index 1 holds key bits 63..0.
// Throughput is one block per cycle while the key chain has settled and the
// output is not stalled. A block passes through the NUM_ROUNDS round cells
// in order, then the output register that adds the final round key.
// The round keys come from a chain of NUM_ROUNDS registered key cells. After
// reset and after every key write, s_axis_tready stays low while the new key
// ripples down that chain. The cfg channel is always ready; write the key
// only while no block is in flight.
// When the receiver holds m_axis_tready low with a beat waiting, the whole
// pipeline freezes and s_axis_tready drops; no beat is lost or repeated.
// Reset clears all valid flags and the key registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "present80_block_cipher_defines.svh"

module present80_block_cipher #(
    parameter int NUM_ROUNDS = prs80_pkg::NUM_ROUNDS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Block input
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [prs80_pkg::BLK_W-1:0]     s_axis_tdata,  // [63:0] data_block
    input  wire logic                            s_axis_tuser,  // [0] opcode
    // Block output
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [prs80_pkg::BLK_W-1:0]     m_axis_tdata,  // [63:0] result_block
    // Key write
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [prs80_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [prs80_pkg::BLK_W-1:0]     i_cfg_data
);
    import prs80_pkg::*;

    localparam int SET_W = $clog2(NUM_ROUNDS + 1);
    localparam logic [SET_W-1:0] SET_MAX = SET_W'(NUM_ROUNDS);

    // Key registers and settle counter
    logic [KEY_HI_W-1:0]      r_key_high;
    logic [BLK_W-1:0]         r_key_low;
    logic [SET_W-1:0]         r_settle;
    logic                     w_cfg_wr;

    // Cell chains
    logic [KEY_W-1:0]         w_key   [0:NUM_ROUNDS];
    t_stage_ctl               w_ctl   [0:NUM_ROUNDS];
    logic [BLK_W-1:0]         w_state [0:NUM_ROUNDS];
    logic                     w_en;

    // Output register
    logic                     r_out_vld;
    logic [BLK_W-1:0]         r_out_data;
    logic [BLK_W-1:0]         n_out_data;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_settle   <= SET_MAX;
        end else begin
            if (w_cfg_wr) begin
                r_settle <= SET_MAX;
                case (i_cfg_index)
                    REG_KEY_HIGH: r_key_high <= i_cfg_data[KEY_HI_W-1:0];
                    REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    default:      ;
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
        end
    end

    // Key schedule chain: cell i holds the key state after i updates.
    assign w_key[0] = {r_key_high, r_key_low};

    for (genvar i = 1; i <= NUM_ROUNDS; i++) begin : g_key
        prs80_key_cell #(
            .RC (i)
        ) u_key (
            .i_clk (i_clk),
            .i_key (w_key[i-1]),
            .o_key (w_key[i])
        );
    end

    // The pipeline moves whenever the output register is free or drained.
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en && (r_settle == '0);

    assign w_ctl[0].vld = s_axis_tvalid & s_axis_tready;
    assign w_ctl[0].op  = s_axis_tuser;
    assign w_state[0]   = s_axis_tdata;

    // Round cell j uses round key j to encrypt and NUM_ROUNDS - j to decrypt.
    for (genvar j = 0; j < NUM_ROUNDS; j++) begin : g_round
        prs80_round_cell u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_ctl    (w_ctl[j]),
            .i_state  (w_state[j]),
            .i_rk_enc (w_key[j][KEY_W-1 -: BLK_W]),
            .i_rk_dec (w_key[NUM_ROUNDS-j][KEY_W-1 -: BLK_W]),
            .o_ctl    (w_ctl[j+1]),
            .o_state  (w_state[j+1])
        );
    end

    always_comb begin
        if (w_ctl[NUM_ROUNDS].op == OP_DEC) begin
            n_out_data = w_state[NUM_ROUNDS] ^ w_key[0][KEY_W-1 -: BLK_W];
        end else begin
            n_out_data = w_state[NUM_ROUNDS] ^ w_key[NUM_ROUNDS][KEY_W-1 -: BLK_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_ctl[NUM_ROUNDS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    `PRS80_ASSERT(a_no_accept_settling, (s_axis_tvalid && s_axis_tready) |-> (r_settle == '0), "block accepted while key chain settles")
    `PRS80_ASSERT(a_cfg_blocks_input, w_cfg_wr |=> !s_axis_tready, "input ready right after a key write")
    `PRS80_ASSERT(a_accept_enters, (s_axis_tvalid && s_axis_tready) |=> w_ctl[1].vld, "accepted beat missing from first round cell")
    `PRS80_ASSERT(a_stall_freezes, !w_en |=> $stable(w_ctl[NUM_ROUNDS].vld) && r_out_vld, "pipeline moved during output stall")
    `PRS80_ASSERT_ALWAYS(a_cfg_ready, o_cfg_ready, "key write channel not ready")

endmodule

`default_nettype wire

>>> verif/tb_present80_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PRESENT-80 block cipher testbench
// Sends blocks through the cipher under several keys, with and without flow
// control gaps on both sides. Each output beat is compared against a
// behavioral encrypt/decrypt computed here from the key last written.
// ----------------------------------------------------------------------------
module tb_present80_block_cipher;

    localparam int ROUNDS = prs80_pkg::NUM_ROUNDS_DEF;
    localparam int BW     = prs80_pkg::BLK_W;

    // Nibble tables, entry n in bits 4n+3..4n.
    localparam logic [63:0] SBOX_FWD = 64'h2174_8FE3_DA09_B65C;
    localparam logic [63:0] SBOX_INV = 64'hA970_364B_D21C_8FE5;

    typedef struct {
        logic          op;
        logic [BW-1:0] blk_in;
        logic [BW-1:0] blk_out;
    } t_block_expect;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [BW-1:0]                     s_axis_tdata = '0;
    logic                              s_axis_tuser = prs80_pkg::OP_ENC;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [BW-1:0]                     m_axis_tdata;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [prs80_pkg::CFG_IDX_W-1:0]   i_cfg_index = prs80_pkg::REG_KEY_HIGH;
    logic [BW-1:0]                     i_cfg_data = '0;

    logic [prs80_pkg::KEY_W-1:0] cipher_key = '0;
    t_block_expect               pending_results[$];
    t_block_expect               head;
    int                          err_count = 0;
    int                          send_idle_pct = 0;
    int                          recv_stall_pct = 0;

    present80_block_cipher #(
        .NUM_ROUNDS(ROUNDS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("present80_block_cipher verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Behavioral cipher
    // ------------------------------------------------------------------------
    function automatic logic [3:0] sbox_lookup(input logic [63:0] lut, input logic [3:0] x);
        return lut[{x, 2'b00} +: 4];
    endfunction

    function automatic logic [BW-1:0] substitute(input logic [BW-1:0] x, input logic [63:0] lut);
        logic [BW-1:0] y;
        for (int n = 0; n < BW / 4; n++) begin
            y[4*n +: 4] = sbox_lookup(lut, x[4*n +: 4]);
        end
        return y;
    endfunction

    // Bit b goes to 16*(b mod 4) + b/4.
    function automatic logic [BW-1:0] spread_bits(input logic [BW-1:0] x);
        logic [BW-1:0] y;
        for (int b = 0; b < BW; b++) begin
            y[16 * (b % 4) + b / 4] = x[b];
        end
        return y;
    endfunction

    function automatic logic [BW-1:0] gather_bits(input logic [BW-1:0] x);
        logic [BW-1:0] y;
        for (int b = 0; b < BW; b++) begin
            y[b] = x[16 * (b % 4) + b / 4];
        end
        return y;
    endfunction

    function automatic logic [BW-1:0] present_transform(input logic [79:0] key,
                                                       input logic op,
                                                       input logic [BW-1:0] blk);
        logic [BW-1:0] rk [0:ROUNDS];
        logic [79:0]   k;
        logic [BW-1:0] s;
        k     = key;
        rk[0] = k[79:16];
        for (int r = 1; r <= ROUNDS; r++) begin
            k          = {k[18:0], k[79:19]};
            k[79:76]   = sbox_lookup(SBOX_FWD, k[79:76]);
            k[19:15]   = k[19:15] ^ r[4:0];
            rk[r]      = k[79:16];
        end
        s = blk;
        if (op == prs80_pkg::OP_ENC) begin
            for (int r = 0; r < ROUNDS; r++) begin
                s = spread_bits(substitute(s ^ rk[r], SBOX_FWD));
            end
            s = s ^ rk[ROUNDS];
        end else begin
            for (int r = ROUNDS; r > 0; r--) begin
                s = substitute(gather_bits(s ^ rk[r]), SBOX_INV);
            end
            s = s ^ rk[0];
        end
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [BW-1:0] want,
                                   input logic [BW-1:0] got);
        $display("[%0t] MISMATCH %s: expected %h got %h", $realtime, what, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("output beat with nothing outstanding", '0, m_axis_tdata);
            end else begin
                head = pending_results.pop_front();
                if (m_axis_tdata !== head.blk_out) begin
                    report_mismatch($sformatf("result_block (op %0d, in %h)", head.op,
                                              head.blk_in),
                                    head.blk_out, m_axis_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_block(input logic op, input logic [BW-1:0] blk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back('{op, blk, present_transform(cipher_key, op, blk)});
    endtask

    // Drops valid and waits until every outstanding block has come back.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [prs80_pkg::CFG_IDX_W-1:0] idx,
                             input logic [BW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == prs80_pkg::REG_KEY_HIGH) begin
            cipher_key[79:64] = data[15:0];
        end else begin
            cipher_key[63:0] = data;
        end
    endtask

    // Only the low 16 bits of the high word are key bits; the rest must be ignored.
    task automatic write_key(input logic [BW-1:0] hi_word, input logic [BW-1:0] lo_word);
        write_reg(prs80_pkg::REG_KEY_HIGH, hi_word);
        write_reg(prs80_pkg::REG_KEY_LOW, lo_word);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_known_vectors();
        logic [BW-1:0] got;
        got = present_transform('0, prs80_pkg::OP_ENC, '0);
        if (got !== 64'h5579C1387B228445) report_mismatch("model zero key", 64'h5579C1387B228445, got);
        got = present_transform('1, prs80_pkg::OP_ENC, '0);
        if (got !== 64'hE72C46C0F5945049) report_mismatch("model ones key", 64'hE72C46C0F5945049, got);
        got = present_transform('0, prs80_pkg::OP_ENC, '1);
        if (got !== 64'hA112FFC72F68417B) report_mismatch("model ones block", 64'hA112FFC72F68417B, got);
        got = present_transform('1, prs80_pkg::OP_ENC, '1);
        if (got !== 64'h3333DCD3213210D2) report_mismatch("model ones both", 64'h3333DCD3213210D2, got);
    endtask

    // The key is all zeros straight out of reset.
    task automatic test_reset_key();
        send_block(prs80_pkg::OP_ENC, '0);
        send_block(prs80_pkg::OP_ENC, '1);
        send_block(prs80_pkg::OP_DEC, 64'h5579C1387B228445);
        send_block(prs80_pkg::OP_DEC, 64'hA112FFC72F68417B);
        wait_for_idle();
    endtask

    task automatic test_key_extremes();
        write_key('1, '1);
        send_block(prs80_pkg::OP_ENC, '0);
        send_block(prs80_pkg::OP_ENC, '1);
        send_block(prs80_pkg::OP_DEC, 64'hE72C46C0F5945049);
        send_block(prs80_pkg::OP_DEC, 64'h3333DCD3213210D2);
        wait_for_idle();
        write_key(64'h0000_0000_0000_8000, 64'h0000_0000_0000_0001);
        send_block(prs80_pkg::OP_ENC, 64'h8000_0000_0000_0001);
        send_block(prs80_pkg::OP_DEC, 64'h0000_0000_0000_0001);
        send_block(prs80_pkg::OP_ENC, 64'h5555_5555_5555_5555);
        send_block(prs80_pkg::OP_DEC, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_for_idle();
        write_key(64'h5555_5555_5555_AAAA, 64'h5555_5555_5555_5555);
        send_block(prs80_pkg::OP_ENC, 64'h0123_4567_89AB_CDEF);
        send_block(prs80_pkg::OP_DEC, 64'hFEDC_BA98_7654_3210);
        wait_for_idle();
    endtask

    task automatic run_random_blocks(input int count);
        logic [BW-1:0] blk;
        int            roll;
        int            sent;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(99);
            blk  = {$urandom, $urandom};
            if (roll < 20) begin
                // Encrypt, then feed the ciphertext straight back for decryption.
                send_block(prs80_pkg::OP_ENC, blk);
                send_block(prs80_pkg::OP_DEC, present_transform(cipher_key,
                                                                 prs80_pkg::OP_ENC, blk));
                sent += 2;
            end else begin
                if (roll < 35) begin
                    case ($urandom_range(3))
                        0: blk = '0;
                        1: blk = '1;
                        2: blk = 64'd1 << $urandom_range(63);
                        default: blk = ~(64'd1 << $urandom_range(63));
                    endcase
                end
                send_block(1'($urandom_range(1)), blk);
                sent++;
            end
        end
    endtask

    task automatic test_idle_phase(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_key({$urandom, $urandom}, {$urandom, $urandom});
        run_random_blocks(240);
        // Hold off the sender until the pipeline has emptied, then rekey.
        wait_for_idle();
        write_key({$urandom, $urandom}, {$urandom, $urandom});
        run_random_blocks(240);
        wait_for_idle();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_known_vectors();
        test_reset_key();
        test_key_extremes();
        test_idle_phase(0, 0);
        test_idle_phase(58, 0);
        test_idle_phase(0, 58);
        test_idle_phase(16, 16);

        repeat (ROUNDS + 9) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("blocks never returned", BW'(pending_results.size()), '0);
        end
        if (err_count == 0) begin
            $display("present80_block_cipher verification clean");
        end else begin
            $display("present80_block_cipher verification failed");
        end
        $finish;
    end

endmodule
